>>> rtl/core/bisl_pkg.sv
// Shared types and codes of the boot image stream loader.
package bisl_pkg;

   localparam int unsigned WordWidth = 32;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SIG_ERR  = 2'd1,
      STATUS_DEV_ERR  = 2'd2,
      STATUS_CSUM_ERR = 2'd3
   } status_type;

   typedef struct packed {
      logic       write_valid;
      word_type   write_address;
      word_type   write_data;
      logic       finished;
      status_type load_status;
      word_type   image_base;
      word_type   image_size;
   } result_type;

endpackage

>>> rtl/core/bisl_core.sv
// Header parsing, checksum and write address state of the loader.
module bisl_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_fire,
   input  bisl_pkg::word_type  csr_data,
   input  logic                item_fire,
   input  bisl_pkg::word_type  word,
   input  logic                device_error,
   output bisl_pkg::result_type result
);
   import bisl_pkg::*;

   typedef enum logic [2:0] {
      PH_SIG      = 3'd0,
      PH_BASE     = 3'd1,
      PH_SIZE     = 3'd2,
      PH_CSUM     = 3'd3,
      PH_DATA     = 3'd4,
      PH_BAD_BASE = 3'd5,
      PH_BAD_SIZE = 3'd6,
      PH_BAD_CSUM = 3'd7
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        sticky_ff, sticky_in;
   word_type    signature_ff;
   word_type    base_ff, base_in;
   word_type    count_ff, count_in;
   word_type    sum_ff, sum_in;
   logic [32:0] offset_ff, offset_in;
   word_type    loaded_ff, loaded_in;

   word_type    sum_data;
   word_type    judge_sum;
   logic [32:0] offset_next;
   logic        err_or;

   assign sum_data    = sum_ff + word;
   assign offset_next = offset_ff + 33'd4;
   assign err_or      = sticky_ff | device_error;
   assign judge_sum   = (phase_ff == PH_DATA) ? sum_data : word;

   always_comb begin
      phase_in  = phase_ff;
      sticky_in = sticky_ff;
      base_in   = base_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      offset_in = offset_ff;
      loaded_in = loaded_ff;
      result    = '0;
      case (phase_ff)
         PH_SIG: begin
            loaded_in = '0;
            sticky_in = device_error;
            phase_in  = (word == signature_ff) ? PH_BASE : PH_BAD_BASE;
         end
         PH_BASE, PH_BAD_BASE: begin
            sticky_in = err_or;
            base_in   = word;
            phase_in  = (phase_ff == PH_BASE) ? PH_SIZE : PH_BAD_SIZE;
         end
         PH_SIZE, PH_BAD_SIZE: begin
            sticky_in = err_or;
            count_in  = word;
            phase_in  = (phase_ff == PH_SIZE) ? PH_CSUM : PH_BAD_CSUM;
         end
         PH_BAD_CSUM: begin
            sum_in             = word;
            result.finished    = 1'b1;
            result.load_status = STATUS_SIG_ERR;
            phase_in           = PH_SIG;
         end
         PH_CSUM: begin
            sticky_in = err_or;
            sum_in    = word;
            offset_in = '0;
            if (err_or || (count_ff == '0)) begin
               result.finished = 1'b1;
               phase_in        = PH_SIG;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            sum_in               = sum_data;
            sticky_in            = err_or;
            offset_in            = offset_next;
            result.write_valid   = 1'b1;
            result.write_address = base_ff + offset_ff[31:0];
            result.write_data    = word;
            if (err_or || (offset_next >= {1'b0, count_ff})) begin
               result.finished = 1'b1;
               phase_in        = PH_SIG;
            end
         end
         default: begin
            phase_in = PH_SIG;
         end
      endcase
      // judge the checksum where a header or data word closes a good load
      if (result.finished && (phase_ff != PH_BAD_CSUM)) begin
         if (err_or) begin
            result.load_status = STATUS_DEV_ERR;
         end else if ((judge_sum + 32'd1) != '0) begin
            result.load_status = STATUS_CSUM_ERR;
         end else begin
            result.load_status = STATUS_OK;
            loaded_in          = count_ff;
         end
      end
      result.image_base = base_in;
      result.image_size = loaded_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIG;
         sticky_ff    <= 1'b0;
         signature_ff <= '0;
         base_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         offset_ff    <= '0;
         loaded_ff    <= '0;
      end else begin
         if (csr_fire) begin
            signature_ff <= csr_data;
         end
         if (item_fire) begin
            phase_ff  <= phase_in;
            sticky_ff <= sticky_in;
            base_ff   <= base_in;
            count_ff  <= count_in;
            sum_ff    <= sum_in;
            offset_ff <= offset_in;
            loaded_ff <= loaded_in;
         end
      end
   end

endmodule

>>> rtl/core/bisl_skid.sv
// Two-entry result register with skid stage.
module bisl_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bisl_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bisl_pkg::result_type out_data
);
   import bisl_pkg::*;

   logic       main_valid_ff;
   logic       skid_valid_ff;
   result_type main_data_ff;
   result_type skid_data_ff;
   logic       in_fire;
   logic       main_take;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign main_take = !main_valid_ff || out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_take) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= in_fire;
         end
      end else if (in_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_take) begin
         main_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end
      if (!main_take && in_fire) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

>>> rtl/core/boot_image_stream_loader_unit.sv
// A result is registered in the output register, or in the skid entry on a consumer stall.
// Throughput: one word per cycle while the skid entry is empty; header, checksum and
// address logic is combinational; a two-entry output buffer absorbs a word on a stall.
// Reset (synchronous, active high) clears the loader state, the signature register and
// both buffer entries; the block accepts words in the first cycle after reset.
module boot_image_stream_loader_unit (
   input  logic          clock,
   input  logic          reset,
   // configuration: expected signature
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [31:0]   csr_data,      // expected_signature[31:0]
   // request stream
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,     // word[31:0]
   input  logic          req_tuser,     // device_error[0]
   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,     // write_address[31:0], write_data[63:32],
                                        // load_status[65:64], image_base[97:66],
                                        // image_size[129:98], zero[135:130]
   output logic          rsp_tuser,     // write_valid[0]
   output logic          rsp_tlast      // finished
);
   import bisl_pkg::*;

   result_type core_result;
   result_type rsp_result;
   logic       req_fire;

   // signature register takes every write
   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;

   // advance the loader state on every request transfer
   bisl_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_fire     (csr_valid && csr_ready),
      .csr_data     (csr_data),
      .item_fire    (req_fire),
      .word         (req_tdata),
      .device_error (req_tuser),
      .result       (core_result)
   );

   // hold results until the consumer takes them
   bisl_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (core_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {6'b0,
                       rsp_result.image_size,
                       rsp_result.image_base,
                       rsp_result.load_status,
                       rsp_result.write_data,
                       rsp_result.write_address};
   assign rsp_tuser = rsp_result.write_valid;
   assign rsp_tlast = rsp_result.finished;

`ifndef ASSERT_OFF
   // a stalled skid entry implies the main entry is occupied
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("skid entry full while output register empty");

   // a status is only reported with the word that ends the load
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_result.finished) |-> (rsp_result.load_status == STATUS_OK))
      else $error("status reported on an unfinished word");

   // a signature failure never carries a memory write
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result.load_status == STATUS_SIG_ERR) |-> !rsp_result.write_valid)
      else $error("write issued with a signature error");

   // a successful load reports the size it consumed, a failed one none
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result.finished && rsp_result.load_status != STATUS_OK)
      |-> (rsp_result.image_size == '0))
      else $error("image size set on a failed load");
`endif

endmodule
